// ===== rtl/core/rrds_pkg.sv =====
// Shared types and constants of the round-robin domain scheduler.
package rrds_pkg;

  localparam int unsigned FuncW   = 2;
  localparam int unsigned DomIdW  = 3;
  localparam int unsigned SliceW  = 32;

  localparam logic [SliceW-1:0] SliceReset = 32'd10000000;

  typedef enum logic [FuncW-1:0] {
    FUNC_SCHEDULE = 2'd0,
    FUNC_WAKE     = 2'd1,
    FUNC_SLEEP    = 2'd2
  } func_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_e;

endpackage

// ===== rtl/core/rrds_req_if.sv =====
// Request channel of the scheduler: valid/ready plus the operation fields.
interface rrds_req_if;
  logic                        valid;
  logic                        ready;
  logic [rrds_pkg::FuncW-1:0]  func;
  logic [rrds_pkg::DomIdW-1:0] target_dom;
  logic                        is_idle_task;

  modport source (output valid, func, target_dom, is_idle_task, input ready);
  modport sink   (input valid, func, target_dom, is_idle_task, output ready);
endinterface

// ===== rtl/core/rrds_rsp_if.sv =====
// Response channel of the scheduler: valid/ready plus the result fields.
interface rrds_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [rrds_pkg::DomIdW-1:0] chosen_domain;
  logic                        idle_chosen;
  logic [rrds_pkg::SliceW-1:0] granted_slice;
  logic                        reschedule_request;

  modport source (output valid, chosen_domain, idle_chosen, granted_slice,
                  reschedule_request, input ready);
  modport sink   (input valid, chosen_domain, idle_chosen, granted_slice,
                  reschedule_request, output ready);
endinterface

// ===== rtl/core/round_robin_domain_scheduler.sv =====
// Round-robin domain scheduler: runnable mask, current domain and slot scanner.
//
// Keeps one runnable bit per domain and the number of the current domain.
// A wake request marks a valid domain runnable and raises reschedule_request;
// a sleep request clears the mark (ignored for the idle task) and raises
// reschedule_request only when it names the current domain. A schedule request
// walks the slots from current+1 round to current, one slot per cycle through
// a single slot incrementer and mask tap, picking the first runnable domain and
// counting runnable slots (saturating at two) to decide the slice. A schedule
// request goes through accept, the scan of every slot and the result write;
// wake, sleep and unknown codes go from accept to the result write. Requests
// are handled one at a time; the result register lets the next request be
// accepted while an earlier result still waits for the sink. Domain numbers
// on the ports are 3 bits wide; chosen_domain carries the low bits of current.
module round_robin_domain_scheduler #(
  parameter int unsigned DOMAIN_COUNT = 8
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        slice_length_we_i,
  input  logic [rrds_pkg::SliceW-1:0] slice_length_i,
  rrds_req_if.sink                    req_i,
  rrds_rsp_if.source                  rsp_o
);
  import rrds_pkg::*;

  localparam int unsigned IdxW = $clog2(DOMAIN_COUNT);
  localparam logic [IdxW-1:0] LastSlot = IdxW'(DOMAIN_COUNT - 1);

  // control and architectural state
  state_e                   state_q, state_d;
  logic [DOMAIN_COUNT-1:0]  mask_q, mask_d;
  logic [IdxW-1:0]          cur_q, cur_d;
  logic [SliceW-1:0]        slice_len_q;
  logic                     out_valid_q;
  logic                     found_q;
  logic [1:0]               run_cnt_q;

  // request capture and scan datapath
  func_e                    func_q;
  logic [DomIdW-1:0]        dom_q;
  logic                     idle_task_q;
  logic [IdxW-1:0]          step_q;
  logic [IdxW-1:0]          slot_q;
  logic [IdxW-1:0]          pick_q;

  // result register
  logic [DomIdW-1:0]        chosen_q;
  logic                     idle_q;
  logic [SliceW-1:0]        slice_out_q;
  logic                     resched_q;

  logic                     accept;
  logic                     load_out;
  logic [DomIdW-1:0]        chosen_d;
  logic                     idle_d;
  logic [SliceW-1:0]        slice_out_d;
  logic                     resched_d;
  logic [IdxW-1:0]          slot_inc;
  logic [IdxW-1:0]          cur_inc;
  logic [IdxW-1:0]          dom_idx;
  logic                     dom_ok;
  logic                     dom_is_cur;

  assign accept   = req_i.valid && req_i.ready;
  assign slot_inc = (slot_q == LastSlot) ? '0 : slot_q + 1'b1;
  assign cur_inc  = (cur_q == LastSlot) ? '0 : cur_q + 1'b1;
  assign dom_idx  = IdxW'(dom_q);
  assign dom_ok   = 32'(dom_q) < 32'(DOMAIN_COUNT);
  assign dom_is_cur = 32'(cur_q) == 32'(dom_q);

  always_comb begin
    state_d     = state_q;
    req_i.ready = 1'b0;
    load_out    = 1'b0;
    mask_d      = mask_q;
    cur_d       = cur_q;
    chosen_d    = chosen_q;
    idle_d      = 1'b0;
    slice_out_d = '0;
    resched_d   = 1'b0;
    case (state_q)
      ST_IDLE: begin
        req_i.ready = 1'b1;
        if (req_i.valid) begin
          state_d = (func_e'(req_i.func) == FUNC_SCHEDULE) ? ST_SCAN : ST_FINISH;
        end
      end
      ST_SCAN: begin
        if (step_q == LastSlot) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!out_valid_q || rsp_o.ready) begin
          load_out = 1'b1;
          state_d  = ST_IDLE;
          case (func_q)
            FUNC_SCHEDULE: begin
              if (found_q) begin
                cur_d = pick_q;
              end
              idle_d      = !found_q;
              slice_out_d = run_cnt_q[1] ? slice_len_q : '0;
            end
            FUNC_WAKE: begin
              if (dom_ok) begin
                mask_d[dom_idx] = 1'b1;
                resched_d       = 1'b1;
              end
            end
            FUNC_SLEEP: begin
              if (dom_ok && !idle_task_q) begin
                mask_d[dom_idx] = 1'b0;
                resched_d       = dom_is_cur;
              end
            end
            default: begin
              // unknown code: state untouched, plain result
            end
          endcase
          chosen_d = DomIdW'(cur_d);
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      mask_q      <= '0;
      cur_q       <= '0;
      slice_len_q <= SliceReset;
      out_valid_q <= 1'b0;
      found_q     <= 1'b0;
      run_cnt_q   <= '0;
    end else begin
      state_q     <= state_d;
      mask_q      <= mask_d;
      cur_q       <= cur_d;
      out_valid_q <= load_out || (out_valid_q && !rsp_o.ready);
      if (slice_length_we_i) begin
        slice_len_q <= slice_length_i;
      end
      if (accept) begin
        found_q   <= 1'b0;
        run_cnt_q <= '0;
      end else if (state_q == ST_SCAN && mask_q[slot_q]) begin
        found_q <= 1'b1;
        if (!run_cnt_q[1]) begin
          run_cnt_q <= run_cnt_q + 1'b1;
        end
      end
    end
  end

  // datapath registers, no reset needed
  always_ff @(posedge clk_i) begin
    if (accept) begin
      func_q      <= func_e'(req_i.func);
      dom_q       <= req_i.target_dom;
      idle_task_q <= req_i.is_idle_task;
      step_q      <= '0;
      slot_q      <= cur_inc;
    end else if (state_q == ST_SCAN) begin
      step_q <= step_q + 1'b1;
      slot_q <= slot_inc;
      if (mask_q[slot_q] && !found_q) begin
        pick_q <= slot_q;
      end
    end
    if (load_out) begin
      chosen_q    <= chosen_d;
      idle_q      <= idle_d;
      slice_out_q <= slice_out_d;
      resched_q   <= resched_d;
    end
  end

  assign rsp_o.valid              = out_valid_q;
  assign rsp_o.chosen_domain      = chosen_q;
  assign rsp_o.idle_chosen        = idle_q;
  assign rsp_o.granted_slice      = slice_out_q;
  assign rsp_o.reschedule_request = resched_q;

  // idle pick never carries a slice
  a_idle_no_slice: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && rsp_o.idle_chosen |-> rsp_o.granted_slice == '0)
    else $error("idle result with non-zero slice");

  // a picked slot must really be runnable while the scan result is pending
  a_pick_runnable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FINISH) && (func_q == FUNC_SCHEDULE) && found_q |-> mask_q[pick_q])
    else $error("picked domain not runnable");

  // empty mask must end the scan with nothing found
  a_empty_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FINISH) && (func_q == FUNC_SCHEDULE) && (mask_q == '0) |-> !found_q)
    else $error("scan found a domain in an empty mask");

  // runnable count of two or more means the scan found something
  a_count_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FINISH) && run_cnt_q[1] |-> found_q)
    else $error("runnable count without a pick");

endmodule
